>>> rtl/bir_pkg.sv
`default_nettype none
package bir_pkg;

  localparam int MAX_SRC_WIDTH  = 256;
  localparam int MAX_SRC_HEIGHT = 256;
  localparam int MAX_DST_SIZE   = 4096;

  localparam int CFG_SW   = 9;   // source size register width
  localparam int CFG_DW   = 13;  // destination size register width
  localparam int COORD_QW = 25;  // 9 integer + 16 fraction bits of a source coordinate
  localparam int CHAN_QW  = 9;   // channel quotient, top bit means saturate
  localparam int DIV_NW   = 46;
  localparam int DIV_DW   = 37;
  localparam int DIV_QW   = 25;
  localparam int KW       = 16;  // Q2.14 tap weight

  typedef enum logic [1:0] {
    REG_SRC_W = 2'd0,
    REG_SRC_H = 2'd1,
    REG_DST_W = 2'd2,
    REG_DST_H = 2'd3
  } reg_idx_t;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_COMPUTE = 1'b1
  } op_t;

  typedef enum logic {
    DIV_COORD = 1'b0,
    DIV_CHAN  = 1'b1
  } div_mode_t;

  typedef struct packed {
    logic      start;
    div_mode_t mode;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef logic signed [KW-1:0] ktab_t [256];

  // Catmull-Rom weight of tap (0..3, offset -1..2) at phase t, rounded half away from zero
  function automatic logic signed [KW-1:0] kernel_q14(input int tap, input int t);
    longint s;
    longint n;
    longint r;
    s = longint'(256 * (tap - 1) - t);
    if (s < 0) s = -s;
    if (s <= 256) n = 3 * s * s * s - 1280 * s * s + (longint'(1) << 25);
    else if (s < 512) n = -s * s * s + 1280 * s * s - 524288 * s + (longint'(1) << 26);
    else n = 0;
    if (n >= 0) r = (n + 1024) / 2048;
    else r = -((-n + 1024) / 2048);
    return KW'(r);
  endfunction

  function automatic ktab_t ktab_build(input int tap);
    ktab_t tb;
    for (int t = 0; t < 256; t++) tb[t] = kernel_q14(tap, t);
    return tb;
  endfunction

endpackage
`default_nettype wire

>>> rtl/bir_in_if.sv
`default_nettype none
interface bir_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] pixel_index;
  logic [7:0]  red_in;
  logic [7:0]  green_in;
  logic [7:0]  blue_in;
  logic [11:0] out_x;
  logic [11:0] out_y;

  modport source (output valid, operation, pixel_index, red_in, green_in, blue_in,
                  out_x, out_y, input ready);
  modport sink   (input valid, operation, pixel_index, red_in, green_in, blue_in,
                  out_x, out_y, output ready);
endinterface
`default_nettype wire

>>> rtl/bir_out_if.sv
`default_nettype none
interface bir_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       coord_error;

  modport source (output valid, red_out, green_out, blue_out, coord_error, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, coord_error, output ready);
endinterface
`default_nettype wire

>>> rtl/bir_mem.sv
`default_nettype none
module bir_mem #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [23:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [23:0]   rdata
);
  logic [23:0] mem_r [DEPTH];
  logic [23:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

>>> rtl/bir_div.sv
`default_nettype none
module bir_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bir_pkg::div_req_t          req,
  input  logic [bir_pkg::DIV_NW-1:0] num,
  input  logic [bir_pkg::DIV_DW-1:0] den,
  output bir_pkg::div_stat_t         stat,
  output logic [bir_pkg::DIV_QW-1:0] quo
);
  import bir_pkg::*;

  logic [DIV_NW-1:0] rem_r;
  logic [DIV_NW-1:0] dsh_r;
  logic [DIV_QW-1:0] q_r;
  logic [4:0]        cnt_r;
  logic              busy_r;
  logic              done_r;
  logic              ge;

  assign ge = (rem_r >= dsh_r);

  // restoring division, one quotient bit per cycle against a right-shifting divisor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        rem_r  <= num;
        q_r    <= '0;
        busy_r <= 1'b1;
        if (req.mode == DIV_COORD) begin
          dsh_r <= DIV_NW'(den) << (COORD_QW - 1);
          cnt_r <= 5'(COORD_QW);
        end else begin
          dsh_r <= DIV_NW'(den) << (CHAN_QW - 1);
          cnt_r <= 5'(CHAN_QW);
        end
      end else if (busy_r) begin
        if (ge) rem_r <= rem_r - dsh_r;
        q_r   <= {q_r[DIV_QW-2:0], ge};
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = q_r;
endmodule
`default_nettype wire

>>> rtl/bicubic_image_resize_top.sv
// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    operation, pixel_index, red/green/blue_in, out_x, out_y
// out_ch    out  valid/ready    red/green/blue_out, coord_error
// APB       in   psel/penable   src_width, src_height, dst_width, dst_height
//
// A compute runs two 25-step coordinate divisions, then 16 taps, each in order
// an address, a memory read with weight product and three channel MACs, then three
// 9-step channel divisions; the divisions all run on one shared bit-serial divider.
// An out-of-range coordinate goes from idle straight to S_DONE. rst_n is synchronous.
// The result sits in an output register; a stalled out_ch holds the next compute at its end.
`default_nettype none
module bicubic_image_resize_top (
  input  logic        clk,
  input  logic        rst_n,
  bir_in_if.sink      in_ch,
  bir_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bir_pkg::*;

  localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  localparam ktab_t KT0 = ktab_build(0);
  localparam ktab_t KT1 = ktab_build(1);
  localparam ktab_t KT2 = ktab_build(2);
  localparam ktab_t KT3 = ktab_build(3);

  typedef enum logic [3:0] {
    S_IDLE, S_GX, S_GXW, S_GY, S_GYW, S_WX, S_WY, S_TOT,
    S_TA, S_TR, S_TM, S_CH, S_CHW, S_DONE
  } state_t;

  state_t               state_r;
  logic [CFG_SW-1:0]    src_w_r, src_h_r;
  logic [CFG_DW-1:0]    dst_w_r, dst_h_r;
  logic [11:0]          ox_r, oy_r;
  logic [8:0]           ix_r, iy_r;
  logic [7:0]           tx_r, ty_r;
  logic signed [KW-1:0] wx_r [4];
  logic signed [KW-1:0] wy_r [4];
  logic signed [17:0]   sx_r;
  logic signed [35:0]   tot_r;
  logic [1:0]           m_r, n_r, ch_r;
  logic [AW-1:0]        addr_r;
  logic signed [31:0]   wt_r;
  logic signed [39:0]   acc_r [3];
  logic [7:0]           res_r [3];
  logic                 err_r;
  logic                 neg_r;
  logic                 out_valid_r;
  logic [7:0]           ro_r, go_r, bo_r;
  logic                 eo_r;

  logic [CFG_SW-1:0]    w_eff, h_eff;
  logic [CFG_DW-1:0]    dw_eff, dh_eff;
  logic                 cfg_wr, in_acc, coord_bad, mem_we;
  logic [20:0]          xprod, yprod;
  logic signed [10:0]   pxs, pys;
  logic [8:0]           px_c, py_c;
  logic [18:0]          addr_c;
  logic signed [17:0]   sx_c, sy_c;
  logic signed [31:0]   wt_c;
  logic [7:0]           chan_c;
  logic signed [39:0]   mac_c;
  logic signed [41:0]   chnum_c;
  logic [23:0]          pix;
  div_req_t             div_req;
  div_stat_t            div_stat;
  logic [DIV_NW-1:0]    div_num;
  logic [DIV_DW-1:0]    div_den;
  logic [DIV_QW-1:0]    div_quo;

  always_comb begin
    if (src_w_r == '0) w_eff = CFG_SW'(1);
    else if (32'(src_w_r) > 32'(MAX_SRC_WIDTH)) w_eff = CFG_SW'(MAX_SRC_WIDTH);
    else w_eff = src_w_r;
    if (src_h_r == '0) h_eff = CFG_SW'(1);
    else if (32'(src_h_r) > 32'(MAX_SRC_HEIGHT)) h_eff = CFG_SW'(MAX_SRC_HEIGHT);
    else h_eff = src_h_r;
    if (32'(dst_w_r) > 32'(MAX_DST_SIZE)) dw_eff = CFG_DW'(MAX_DST_SIZE);
    else dw_eff = dst_w_r;
    if (32'(dst_h_r) > 32'(MAX_DST_SIZE)) dh_eff = CFG_DW'(MAX_DST_SIZE);
    else dh_eff = dst_h_r;
  end

  assign cfg_wr    = psel && penable && pwrite;
  assign pready    = 1'b1;
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign coord_bad = ({1'b0, in_ch.out_x} >= dw_eff) || ({1'b0, in_ch.out_y} >= dh_eff);
  assign mem_we    = in_acc && (op_t'(in_ch.operation) == OP_LOAD) &&
                     (32'(in_ch.pixel_index) < 32'(DEPTH));

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_SRC_W: prdata = 32'(src_w_r);
      REG_SRC_H: prdata = 32'(src_h_r);
      REG_DST_W: prdata = 32'(dst_w_r);
      REG_DST_H: prdata = 32'(dst_h_r);
      default:   prdata = '0;
    endcase
  end

  assign xprod = 21'(ox_r) * 21'(w_eff);
  assign yprod = 21'(oy_r) * 21'(h_eff);

  // neighbor position, clamped to the image edges
  always_comb begin
    pxs = $signed({2'b00, ix_r}) + $signed({9'd0, n_r}) - 11'sd1;
    pys = $signed({2'b00, iy_r}) + $signed({9'd0, m_r}) - 11'sd1;
    if (pxs < 0) px_c = '0;
    else if (pxs > $signed({2'b00, w_eff}) - 11'sd1) px_c = w_eff - 9'd1;
    else px_c = pxs[8:0];
    if (pys < 0) py_c = '0;
    else if (pys > $signed({2'b00, h_eff}) - 11'sd1) py_c = h_eff - 9'd1;
    else py_c = pys[8:0];
  end

  assign addr_c = 19'(py_c) * 19'(w_eff) + 19'(px_c);
  assign sx_c   = 18'(wx_r[0]) + 18'(wx_r[1]) + 18'(wx_r[2]) + 18'(wx_r[3]);
  assign sy_c   = 18'(wy_r[0]) + 18'(wy_r[1]) + 18'(wy_r[2]) + 18'(wy_r[3]);
  assign wt_c   = 32'(wx_r[n_r]) * 32'(wy_r[m_r]);

  always_comb begin
    case (ch_r)
      2'd0:    chan_c = pix[23:16];
      2'd1:    chan_c = pix[15:8];
      default: chan_c = pix[7:0];
    endcase
  end

  assign mac_c   = 40'($signed({1'b0, chan_c})) * 40'(wt_r);
  assign chnum_c = (42'(acc_r[ch_r]) <<< 1) + 42'(tot_r);

  always_comb begin
    div_req = '0;
    div_num = '0;
    div_den = '0;
    case (state_r)
      S_GX: begin
        div_req.start = 1'b1;
        div_req.mode  = DIV_COORD;
        div_num       = DIV_NW'({xprod, 16'h0000});
        div_den       = DIV_DW'(dw_eff);
      end
      S_GY: begin
        div_req.start = 1'b1;
        div_req.mode  = DIV_COORD;
        div_num       = DIV_NW'({yprod, 16'h0000});
        div_den       = DIV_DW'(dh_eff);
      end
      S_CH: begin
        div_req.start = 1'b1;
        div_req.mode  = DIV_CHAN;
        div_num       = DIV_NW'(chnum_c);
        div_den       = DIV_DW'({tot_r, 1'b0});
      end
      default: ;
    endcase
  end

  bir_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(in_ch.pixel_index)),
    .wdata ({in_ch.red_in, in_ch.green_in, in_ch.blue_in}),
    .raddr (addr_r),
    .rdata (pix)
  );

  bir_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      src_w_r     <= 9'd256;
      src_h_r     <= 9'd256;
      dst_w_r     <= 13'd256;
      dst_h_r     <= 13'd256;
      m_r         <= '0;
      n_r         <= '0;
      ch_r        <= '0;
    end else begin
      if (cfg_wr) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_SRC_W: src_w_r <= pwdata[CFG_SW-1:0];
          REG_SRC_H: src_h_r <= pwdata[CFG_SW-1:0];
          REG_DST_W: dst_w_r <= pwdata[CFG_DW-1:0];
          REG_DST_H: dst_h_r <= pwdata[CFG_DW-1:0];
          default: ;
        endcase
      end
      if (state_r == S_DONE && (!out_valid_r || out_ch.ready)) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_acc && op_t'(in_ch.operation) == OP_COMPUTE) begin
            ox_r <= in_ch.out_x;
            oy_r <= in_ch.out_y;
            if (coord_bad) begin
              res_r[0] <= '0;
              res_r[1] <= '0;
              res_r[2] <= '0;
              err_r    <= 1'b1;
              state_r  <= S_DONE;
            end else begin
              err_r   <= 1'b0;
              state_r <= S_GX;
            end
          end
        end
        S_GX: state_r <= S_GXW;
        S_GXW: begin
          if (div_stat.done) begin
            ix_r    <= div_quo[24:16];
            tx_r    <= div_quo[15:8];
            state_r <= S_GY;
          end
        end
        S_GY: state_r <= S_GYW;
        S_GYW: begin
          if (div_stat.done) begin
            iy_r    <= div_quo[24:16];
            ty_r    <= div_quo[15:8];
            state_r <= S_WX;
          end
        end
        S_WX: begin
          wx_r[0] <= KT0[tx_r];
          wx_r[1] <= KT1[tx_r];
          wx_r[2] <= KT2[tx_r];
          wx_r[3] <= KT3[tx_r];
          state_r <= S_WY;
        end
        S_WY: begin
          wy_r[0] <= KT0[ty_r];
          wy_r[1] <= KT1[ty_r];
          wy_r[2] <= KT2[ty_r];
          wy_r[3] <= KT3[ty_r];
          sx_r    <= sx_c;
          state_r <= S_TOT;
        end
        S_TOT: begin
          // separable kernel: total weight is the product of the row and column sums
          tot_r    <= 36'(sx_r) * 36'(sy_c);
          acc_r[0] <= '0;
          acc_r[1] <= '0;
          acc_r[2] <= '0;
          m_r      <= '0;
          n_r      <= '0;
          state_r  <= S_TA;
        end
        S_TA: begin
          addr_r  <= AW'(addr_c);
          state_r <= S_TR;
        end
        S_TR: begin
          wt_r    <= wt_c;
          ch_r    <= '0;
          state_r <= S_TM;
        end
        S_TM: begin
          acc_r[ch_r] <= acc_r[ch_r] + mac_c;
          if (ch_r == 2'd2) begin
            ch_r <= '0;
            n_r  <= n_r + 2'd1;
            if (n_r == 2'd3) begin
              m_r <= m_r + 2'd1;
              if (m_r == 2'd3) state_r <= S_CH;
              else state_r <= S_TA;
            end else begin
              state_r <= S_TA;
            end
          end else begin
            ch_r <= ch_r + 2'd1;
          end
        end
        S_CH: begin
          neg_r   <= chnum_c[41];
          state_r <= S_CHW;
        end
        S_CHW: begin
          if (div_stat.done) begin
            if (neg_r) res_r[ch_r] <= '0;
            else if (div_quo[CHAN_QW-1]) res_r[ch_r] <= 8'd255;
            else res_r[ch_r] <= div_quo[7:0];
            if (ch_r == 2'd2) begin
              ch_r    <= '0;
              state_r <= S_DONE;
            end else begin
              ch_r    <= ch_r + 2'd1;
              state_r <= S_CH;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            ro_r    <= res_r[0];
            go_r    <= res_r[1];
            bo_r    <= res_r[2];
            eo_r    <= err_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.red_out     = ro_r;
  assign out_ch.green_out   = go_r;
  assign out_ch.blue_out    = bo_r;
  assign out_ch.coord_error = eo_r;
endmodule
`default_nettype wire

>>> rtl/bir_chk.sv
`default_nettype none
module bir_chk (
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_ready,
  input wire       in_operation,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] red_out,
  input wire [7:0] green_out,
  input wire [7:0] blue_out,
  input wire       coord_error
);
  import bir_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(red_out) && $stable(green_out) &&
    $stable(blue_out) && $stable(coord_error))
    else $error("result changed while stalled");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == OP_LOAD && !out_valid |=> !out_valid)
    else $error("load produced a result");

  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == OP_COMPUTE |=> !in_ready)
    else $error("ready during compute");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && coord_error |-> red_out == 8'd0 && green_out == 8'd0 && blue_out == 8'd0)
    else $error("error result carries color");
endmodule

bind bicubic_image_resize_top bir_chk u_bir_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_operation (in_ch.operation),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .red_out      (out_ch.red_out),
  .green_out    (out_ch.green_out),
  .blue_out     (out_ch.blue_out),
  .coord_error  (out_ch.coord_error)
);
`default_nettype wire
